FILE: hw/rtl/bba_pkg.sv
// buddy block allocator: shared payload types and codes
// no dependencies
package bba_pkg;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;

  // configuration register indexes
  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  localparam int CFG_DW  = 6;
  localparam int ADDR_W  = 18;
  localparam int REQ_W   = 24;
  localparam int NEED_W  = 26;
  localparam int GLVL_W  = 4;
  localparam int HDR_W   = 6;
  localparam int LIM_W   = 3;
  localparam logic [LIM_W-1:0] LIMIT_RESET  = 3'd4;
  localparam logic [HDR_W-1:0] HEADER_RESET = 6'd24;

  typedef struct packed {
    logic              operation;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] free_address;
    logic              null_pointer;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] payload_address;
    logic [GLVL_W-1:0] granted_level;
  } bba_out_t;

  // write enables of the four per-granule stores
  typedef struct packed {
    logic nxt;
    logic prv;
    logic lvl;
    logic res;
  } bba_wen_t;

endpackage

FILE: hw/rtl/bba_store.sv
// buddy block allocator: per-granule link, level and reserved stores
// depends on bba_pkg
module bba_store
  import bba_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int IW    = 12,
  parameter int LKW   = 13,
  parameter int LW    = 4
) (
  input  logic           clk,
  input  bba_wen_t       wen,
  input  logic [IW-1:0]  wr_addr,
  input  logic [LKW-1:0] wr_next,
  input  logic [LKW-1:0] wr_prev,
  input  logic [LW-1:0]  wr_lvl,
  input  logic           wr_res,
  input  logic [IW-1:0]  rd_addr,
  output logic [LKW-1:0] rd_next,
  output logic [LKW-1:0] rd_prev,
  output logic [LW-1:0]  rd_lvl,
  output logic           rd_res
);

  logic [LKW-1:0] next_mem [DEPTH];
  logic [LKW-1:0] prev_mem [DEPTH];
  logic [LW-1:0]  lvl_mem  [DEPTH];
  logic           res_mem  [DEPTH];

  // one write port, one registered read port per store
  always_ff @(posedge clk) begin
    if (wen.nxt) next_mem[wr_addr] <= wr_next;
    if (wen.prv) prev_mem[wr_addr] <= wr_prev;
    if (wen.lvl) lvl_mem[wr_addr]  <= wr_lvl;
    if (wen.res) res_mem[wr_addr]  <= wr_res;
    rd_next <= next_mem[rd_addr];
    rd_prev <= prev_mem[rd_addr];
    rd_lvl  <= lvl_mem[rd_addr];
    rd_res  <= res_mem[rd_addr];
  end

endmodule

FILE: hw/rtl/bba_seq.sv
// buddy block allocator: sequencer, list heads, config and result register
// depends on bba_pkg, drives bba_store through its ports
module bba_seq
  import bba_pkg::*;
#(
  parameter int MIN_ORDER  = 6,
  parameter int MAX_ORDER  = 16,
  parameter int TOP_BLOCKS = 4,
  parameter int LEVELS     = MAX_ORDER - MIN_ORDER,
  parameter int GRAN       = TOP_BLOCKS << LEVELS,
  parameter int IW         = $clog2(GRAN),
  parameter int LKW        = IW + 1,
  parameter int LW         = $clog2(LEVELS + 2)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bba_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bba_out_t           out_data,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_wdata,
  output bba_wen_t           wen,
  output logic [IW-1:0]      wr_addr,
  output logic [LKW-1:0]     wr_next,
  output logic [LKW-1:0]     wr_prev,
  output logic [LW-1:0]      wr_lvl,
  output logic               wr_res,
  output logic [IW-1:0]      rd_addr,
  input  logic [LKW-1:0]     rd_next,
  input  logic [LKW-1:0]     rd_prev,
  input  logic [LW-1:0]      rd_lvl,
  input  logic               rd_res
);

  localparam int HIW = $clog2(LEVELS + 1);
  localparam int GBW = $clog2(TOP_BLOCKS + 1);
  localparam logic [LKW-1:0] NIL = LKW'(GRAN);
  localparam logic [LW-1:0]  TOP_LVL = LW'(LEVELS);
  localparam int GW = ADDR_W - MIN_ORDER;

  typedef enum logic [4:0] {
    S_IDLE, S_WANT, S_SEARCH, S_LOAD, S_RM_A, S_RM_B, S_SPLIT, S_PUSH,
    S_PUSH_LINK, S_ALLOC_FIN, S_GROW, S_FREE_CHK, S_MERGE, S_MERGE_CHK
  } state_t;

  typedef enum logic [1:0] {R_SPLIT, R_GROW, R_FREE} ret_t;

  state_t              state_r, state_nxt;
  ret_t                ret_r, ret_nxt;
  logic                op_r, op_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [LW-1:0]       want_r, want_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic [IW-1:0]       g_r, g_nxt;
  logic [IW-1:0]       b_r, b_nxt;
  logic [IW-1:0]       x_r, x_nxt;
  logic [LKW-1:0]      h_r, h_nxt;
  logic [LKW-1:0]      p_r, p_nxt;
  logic [LKW-1:0]      n_r, n_nxt;
  logic [GBW-1:0]      grown_r, grown_nxt;
  logic [HDR_W-1:0]    hdr_r;
  logic [LIM_W-1:0]    lim_r;
  logic [LKW-1:0]      head_r [LEVELS+1];
  logic                head_we;
  logic [LKW-1:0]      head_wd;
  logic                out_valid_r, out_valid_nxt;
  bba_out_t            out_r, out_nxt;

  logic [HIW-1:0]      hidx;
  logic [LKW-1:0]      head_cur;
  logic [NEED_W-1:0]   need_in;
  logic [ADDR_W-1:0]   off;
  logic [GW-1:0]       gg;
  logic [31:0]         heap_gran;
  logic [GBW-1:0]      lim_eff;

  assign hidx      = lvl_r[HIW-1:0];
  assign head_cur  = head_r[hidx];
  assign need_in   = NEED_W'(in_data.request_bytes) + NEED_W'(hdr_r);
  assign off       = in_data.free_address - ADDR_W'(hdr_r);
  assign gg        = off[ADDR_W-1:MIN_ORDER];
  assign heap_gran = 32'(grown_r) << LEVELS;
  assign lim_eff   = (32'(lim_r) < 32'(TOP_BLOCKS)) ? GBW'(lim_r) : GBW'(TOP_BLOCKS);

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer next state and store commands
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    op_nxt        = op_r;
    need_nxt      = need_r;
    want_nxt      = want_r;
    lvl_nxt       = lvl_r;
    g_nxt         = g_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    h_nxt         = h_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    grown_nxt     = grown_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    head_we       = 1'b0;
    head_wd       = NIL;
    wen           = '0;
    wr_addr       = x_r;
    wr_next       = head_cur;
    wr_prev       = NIL;
    wr_lvl        = lvl_r;
    wr_res        = 1'b0;
    rd_addr       = g_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt = in_data.operation;
          out_nxt = '{status: ST_FREED, payload_address: '0, granted_level: '0};
          if (in_data.operation == OP_ALLOC) begin
            need_nxt = need_in;
            want_nxt = '0;
            if (in_data.request_bytes == '0 ||
                need_in > (NEED_W'(1) << MAX_ORDER)) begin
              out_nxt.status = ST_FAIL;
              out_valid_nxt  = 1'b1;
            end else begin
              state_nxt = S_WANT;
            end
          end else if (in_data.null_pointer ||
                       off[MIN_ORDER-1:0] != '0 ||
                       32'(gg) >= heap_gran || 32'(gg) >= 32'(GRAN)) begin
            out_valid_nxt = 1'b1;
          end else begin
            g_nxt     = IW'(gg);
            rd_addr   = IW'(gg);
            state_nxt = S_FREE_CHK;
          end
        end
      end

      // round the need up to a power of two, one compare a cycle
      S_WANT: begin
        if (want_r < TOP_LVL &&
            need_r > (NEED_W'(1) << (MIN_ORDER + int'(want_r)))) begin
          want_nxt = want_r + 1'b1;
        end else begin
          lvl_nxt   = want_r;
          state_nxt = S_SEARCH;
        end
      end

      // walk up the levels for a non-empty list
      S_SEARCH: begin
        if (lvl_r > TOP_LVL) begin
          state_nxt = S_GROW;
        end else if (head_cur == NIL) begin
          lvl_nxt = lvl_r + 1'b1;
        end else begin
          g_nxt     = head_cur[IW-1:0];
          rd_addr   = head_cur[IW-1:0];
          b_nxt     = head_cur[IW-1:0];
          state_nxt = S_LOAD;
        end
      end

      S_LOAD: begin
        p_nxt     = rd_prev;
        n_nxt     = rd_next;
        state_nxt = S_RM_A;
      end

      // unlink: forward link of predecessor, or the list head
      S_RM_A: begin
        if (p_r < NIL) begin
          wen.nxt = 1'b1;
          wr_addr = p_r[IW-1:0];
          wr_next = n_r;
        end else begin
          head_we = 1'b1;
          head_wd = n_r;
        end
        state_nxt = S_RM_B;
      end

      // unlink: back link of successor
      S_RM_B: begin
        if (n_r < NIL) begin
          wen.prv = 1'b1;
          wr_addr = n_r[IW-1:0];
          wr_prev = p_r;
        end
        if (op_r == OP_ALLOC) begin
          state_nxt = S_SPLIT;
        end else begin
          if (b_r < g_r) g_nxt = b_r;
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_MERGE;
        end
      end

      // halve the block, upper half goes on its list
      S_SPLIT: begin
        if (lvl_r > want_r) begin
          lvl_nxt   = lvl_r - 1'b1;
          x_nxt     = g_r + (IW'(1) << (lvl_r - 1'b1));
          ret_nxt   = R_SPLIT;
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_ALLOC_FIN;
        end
      end

      // push x on list lvl: its own word first
      S_PUSH: begin
        wen       = '{nxt: 1'b1, prv: 1'b1, lvl: 1'b1, res: 1'b1};
        wr_addr   = x_r;
        wr_next   = head_cur;
        wr_prev   = NIL;
        wr_lvl    = lvl_r;
        wr_res    = 1'b0;
        h_nxt     = head_cur;
        head_we   = 1'b1;
        head_wd   = LKW'(x_r);
        state_nxt = S_PUSH_LINK;
      end

      S_PUSH_LINK: begin
        if (h_r < NIL) begin
          wen.prv = 1'b1;
          wr_addr = h_r[IW-1:0];
          wr_prev = LKW'(x_r);
        end
        case (ret_r)
          R_SPLIT: state_nxt = S_SPLIT;
          R_GROW: begin
            lvl_nxt   = want_r;
            state_nxt = S_SEARCH;
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end

      S_ALLOC_FIN: begin
        wen.lvl = 1'b1;
        wen.res = 1'b1;
        wr_addr = g_r;
        wr_lvl  = lvl_r;
        wr_res  = 1'b1;
        out_nxt.status          = ST_OK;
        out_nxt.payload_address = ADDR_W'((32'(g_r) << MIN_ORDER) + 32'(hdr_r));
        out_nxt.granted_level   = GLVL_W'(want_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // add one top-level block to the heap, or fail once the limit is reached
      S_GROW: begin
        if (grown_r < lim_eff) begin
          x_nxt     = IW'(32'(grown_r) << LEVELS);
          lvl_nxt   = TOP_LVL;
          grown_nxt = grown_r + 1'b1;
          ret_nxt   = R_GROW;
          state_nxt = S_PUSH;
        end else begin
          out_nxt.status = ST_FAIL;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_FREE_CHK: begin
        if (!rd_res || rd_lvl > TOP_LVL) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          lvl_nxt   = rd_lvl;
          wen.res   = 1'b1;
          wr_addr   = g_r;
          wr_res    = 1'b0;
          state_nxt = S_MERGE;
        end
      end

      // look at the buddy on this level, or push the block once at the top level
      S_MERGE: begin
        if (lvl_r < TOP_LVL) begin
          b_nxt     = g_r ^ (IW'(1) << lvl_r);
          rd_addr   = g_r ^ (IW'(1) << lvl_r);
          state_nxt = S_MERGE_CHK;
        end else begin
          x_nxt     = g_r;
          ret_nxt   = R_FREE;
          state_nxt = S_PUSH;
        end
      end

      S_MERGE_CHK: begin
        if (rd_res || rd_lvl != lvl_r) begin
          x_nxt     = g_r;
          ret_nxt   = R_FREE;
          state_nxt = S_PUSH;
        end else begin
          p_nxt     = rd_prev;
          n_nxt     = rd_next;
          state_nxt = S_RM_A;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state, list heads, config and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= R_SPLIT;
      grown_r     <= '0;
      out_valid_r <= 1'b0;
      hdr_r       <= HEADER_RESET;
      lim_r       <= LIMIT_RESET;
      for (int i = 0; i <= LEVELS; i++) head_r[i] <= NIL;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      grown_r     <= grown_nxt;
      out_valid_r <= out_valid_nxt;
      if (head_we) head_r[hidx] <= head_wd;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_HEADER: hdr_r <= cfg_wdata[HDR_W-1:0];
          CFG_LIMIT:  lim_r <= cfg_wdata[LIM_W-1:0];
          default: ;
        endcase
      end
    end
    op_r   <= op_nxt;
    need_r <= need_nxt;
    want_r <= want_nxt;
    lvl_r  <= lvl_nxt;
    g_r    <= g_nxt;
    b_r    <= b_nxt;
    x_r    <= x_nxt;
    h_r    <= h_nxt;
    p_r    <= p_nxt;
    n_r    <= n_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: hw/rtl/buddy_block_allocator_top.sv
// buddy block allocator top level: sequencer plus granule stores
// depends on bba_pkg, bba_seq, bba_store
//
//   channel | direction | handshake          | word
//   in_     | in        | in_valid/in_ready  | bba_in_t
//   out_    | out       | out_valid/out_ready| bba_out_t
//   cfg_    | in        | cfg_we             | index cfg_addr, data cfg_wdata
//
// one word at a time; ready stays low from acceptance until its result is taken
// an allocate rounds its need up to a power of two, searches the level lists
// for a free block, then unlinks and splits it, and growing the heap adds a full
// second search; a free unlinks and merges with its buddy level by level
// synchronous active-low reset empties all level lists and the grown count;
// the granule stores are not cleared and need no clearing pass
// a result waits in the output register while out_ready is low
module buddy_block_allocator_top
  import bba_pkg::*;
#(
  parameter int MIN_ORDER  = 6,
  parameter int MAX_ORDER  = 16,
  parameter int TOP_BLOCKS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_out_t          out_data,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int LEVELS = MAX_ORDER - MIN_ORDER;
  localparam int GRAN   = TOP_BLOCKS << LEVELS;
  localparam int IW     = $clog2(GRAN);
  localparam int LKW    = IW + 1;
  localparam int LW     = $clog2(LEVELS + 2);

  bba_wen_t       wen;
  logic [IW-1:0]  wr_addr, rd_addr;
  logic [LKW-1:0] wr_next, wr_prev, rd_next, rd_prev;
  logic [LW-1:0]  wr_lvl, rd_lvl;
  logic           wr_res, rd_res;

  // control sequencer
  bba_seq #(
    .MIN_ORDER(MIN_ORDER), .MAX_ORDER(MAX_ORDER), .TOP_BLOCKS(TOP_BLOCKS),
    .LEVELS(LEVELS), .GRAN(GRAN), .IW(IW), .LKW(LKW), .LW(LW)
  ) u_seq (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_addr, .cfg_wdata, .wen, .wr_addr, .wr_next,
    .wr_prev, .wr_lvl, .wr_res, .rd_addr, .rd_next, .rd_prev, .rd_lvl, .rd_res
  );

  // granule stores
  bba_store #(.DEPTH(GRAN), .IW(IW), .LKW(LKW), .LW(LW)) u_store (
    .clk, .wen, .wr_addr, .wr_next, .wr_prev, .wr_lvl, .wr_res,
    .rd_addr, .rd_next, .rd_prev, .rd_lvl, .rd_res
  );

endmodule

FILE: hw/rtl/bba_checker.sv
// buddy block allocator: port-level checks, bound to the top level
// depends on bba_pkg
module bba_checker
  import bba_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input bba_out_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // busy after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after acceptance");

  // no intake while a result waits
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready high while result pending");

  // only grants carry an address
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.payload_address == '0 && out_data.granted_level == '0)
    else $error("address on non-grant result");

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
